>>> rtl/hashed_name_list_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Hashed name list filter - assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef HASHED_NAME_LIST_FILTER_UNIT_MACROS_SVH
`define HASHED_NAME_LIST_FILTER_UNIT_MACROS_SVH

// cond must hold at every edge out of reset
`define HNLF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// cons must hold at every edge where ante holds
`define HNLF_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/hnlf_pkg.sv
// ----------------------------------------------------------------------------
// Hashed name list filter - package
// Sizes, codes and beat types shared by the filter unit.
// ----------------------------------------------------------------------------
package hnlf_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned HASH_WIDTH  = 64;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [HASH_WIDTH-1:0] HASH_SEED = HASH_WIDTH'(5381);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_DUP  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_INSERT = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        excluded;
    status_e     status;
    logic [63:0] name_hash;
    logic [8:0]  entry_count;
  } out_beat_t;

endpackage

>>> rtl/hnlf_ram.sv
// ----------------------------------------------------------------------------
// Hashed name list filter - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hnlf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hashed_name_list_filter_unit.sv
// Flow: a byte that does not end a name only updates the hash; clear resets
// count and hash. A final byte runs a binary search of up to log2(entries)+1
// probes. An insert first moves the entries above the slot up one by one
// through the single table RAM port pair when the slot is not at the end.
// Throughput: one item in flight; a stalled answer beat holds the unit.
// Reset: entry count 0, hash at seed, list_mode 0; table contents undefined.
// ----------------------------------------------------------------------------
// Hashed name list filter unit
// djb2 hash of streamed names, sorted hash table with insert and lookup.
// ----------------------------------------------------------------------------
module hashed_name_list_filter_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hnlf_pkg::in_beat_t   in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hnlf_pkg::out_beat_t  out_beat_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  `include "hashed_name_list_filter_unit_macros.svh"

  localparam int unsigned HW = hnlf_pkg::HASH_WIDTH;
  localparam int unsigned CW = hnlf_pkg::CW;
  localparam int unsigned AW = hnlf_pkg::AW;

  hnlf_pkg::state_e    state_q, state_d;
  logic [HW-1:0]       hash_q, hash_d;
  logic [HW-1:0]       key_q, key_d;
  logic                is_load_q, is_load_d;
  logic [CW-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                found_q, found_d;
  logic                pend_q, pend_d;
  logic [CW-1:0]       sh_idx_q, sh_idx_d, sh_waddr_q, sh_waddr_d;
  logic                sh_more_q, sh_more_d, sh_wv_q, sh_wv_d;
  logic [CW-1:0]       count_q, count_d;
  logic                mode_q;
  logic                out_valid_q, out_valid_d;
  hnlf_pkg::out_beat_t out_q, out_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [HW-1:0] ram_wdata, ram_rdata;

  logic          in_acc, out_free;
  logic [HW-1:0] hash_nxt;
  logic [CW-1:0] lo_n, hi_n, mid_n, sh_wnext;
  logic          found_n;

  assign in_stall_o = (state_q != hnlf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hash_nxt   = (hash_q << 5) + hash_q + HW'(in_beat_i.char_byte);
  assign sh_wnext   = sh_waddr_q + CW'(1);

  // config port
  assign pready = 1'b1;
  assign prdata = 32'(mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mode_q <= pwdata[0];
    end
  end

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    key_d       = key_q;
    is_load_d   = is_load_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    found_d     = found_q;
    pend_d      = pend_q;
    sh_idx_d    = sh_idx_q;
    sh_waddr_d  = sh_waddr_q;
    sh_more_d   = sh_more_q;
    sh_wv_d     = sh_wv_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    lo_n        = lo_q;
    hi_n        = hi_q;
    found_n     = found_q;
    mid_n       = '0;

    case (state_q)
      hnlf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (hnlf_pkg::cmd_e'(in_beat_i.command))
            hnlf_pkg::CMD_CLEAR: begin
              count_d = '0;
              hash_d  = hnlf_pkg::HASH_SEED;
            end
            hnlf_pkg::CMD_LOAD, hnlf_pkg::CMD_QUERY: begin
              if (!in_beat_i.last_byte) begin
                hash_d = hash_nxt;
              end else begin
                hash_d    = hnlf_pkg::HASH_SEED;
                key_d     = hash_nxt;
                is_load_d = (in_beat_i.command == hnlf_pkg::CMD_LOAD);
                lo_d      = '0;
                hi_d      = count_q;
                found_d   = 1'b0;
                pend_d    = 1'b0;
                state_d   = hnlf_pkg::ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      hnlf_pkg::ST_SEARCH: begin
        // lower-bound search; table entries are unique, so a hit marks the slot
        if (pend_q) begin
          if (ram_rdata < key_q) begin
            lo_n = mid_q + CW'(1);
          end else begin
            hi_n = mid_q;
          end
          if (ram_rdata == key_q) begin
            found_n = 1'b1;
          end
        end
        mid_n   = lo_n + ((hi_n - lo_n) >> 1);
        lo_d    = lo_n;
        hi_d    = hi_n;
        found_d = found_n;
        pend_d  = 1'b0;
        if (lo_n < hi_n) begin
          ram_re    = 1'b1;
          ram_raddr = mid_n[AW-1:0];
          mid_d     = mid_n;
          pend_d    = 1'b1;
        end else if (is_load_q && !found_n &&
                     (count_q < CW'(hnlf_pkg::TABLE_DEPTH))) begin
          if (lo_n == count_q) begin
            state_d = hnlf_pkg::ST_INSERT;
          end else begin
            sh_idx_d  = count_q - CW'(1);
            sh_more_d = 1'b1;
            sh_wv_d   = 1'b0;
            state_d   = hnlf_pkg::ST_SHIFT;
          end
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.excluded       = !is_load_q && (found_n == mode_q);
          out_d.status         = !is_load_q ? hnlf_pkg::STAT_OK :
                                 (found_n ? hnlf_pkg::STAT_DUP : hnlf_pkg::STAT_FULL);
          out_d.name_hash      = 64'(key_q);
          out_d.entry_count    = 9'(count_q);
          state_d              = hnlf_pkg::ST_IDLE;
        end
      end

      hnlf_pkg::ST_SHIFT: begin
        // read entry i while entry i+1 (read last cycle) is written back one up
        if (sh_wv_q) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wnext[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (sh_more_q) begin
          ram_re     = 1'b1;
          ram_raddr  = sh_idx_q[AW-1:0];
          sh_wv_d    = 1'b1;
          sh_waddr_d = sh_idx_q;
          if (sh_idx_q == lo_q) begin
            sh_more_d = 1'b0;
          end else begin
            sh_idx_d = sh_idx_q - CW'(1);
          end
        end else begin
          sh_wv_d = 1'b0;
          state_d = hnlf_pkg::ST_INSERT;
        end
      end

      hnlf_pkg::ST_INSERT: begin
        if (out_free) begin
          ram_we            = 1'b1;
          ram_waddr         = lo_q[AW-1:0];
          ram_wdata         = key_q;
          count_d           = count_q + CW'(1);
          out_valid_d       = 1'b1;
          out_d.excluded    = 1'b0;
          out_d.status      = hnlf_pkg::STAT_OK;
          out_d.name_hash   = 64'(key_q);
          out_d.entry_count = 9'(count_q + CW'(1));
          state_d           = hnlf_pkg::ST_IDLE;
        end
      end

      default: state_d = hnlf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hnlf_pkg::ST_IDLE;
      hash_q      <= hnlf_pkg::HASH_SEED;
      count_q     <= '0;
      pend_q      <= 1'b0;
      sh_more_q   <= 1'b0;
      sh_wv_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      sh_more_q   <= sh_more_d;
      sh_wv_q     <= sh_wv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    is_load_q  <= is_load_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    found_q    <= found_d;
    sh_idx_q   <= sh_idx_d;
    sh_waddr_q <= sh_waddr_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  hnlf_ram #(
    .Width (hnlf_pkg::HASH_WIDTH),
    .Depth (hnlf_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `HNLF_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(hnlf_pkg::TABLE_DEPTH),
    "entry count above table depth")
  `HNLF_ASSERT_IMPLY(a_shift_no_overlap, ram_we && ram_re, ram_waddr != ram_raddr,
    "table read and write hit the same entry")
  `HNLF_ASSERT_IMPLY(a_search_window, state_q == hnlf_pkg::ST_SEARCH, lo_q <= hi_q,
    "search window inverted")
  `HNLF_ASSERT_IMPLY(a_insert_room, state_q == hnlf_pkg::ST_INSERT,
    count_q != CW'(hnlf_pkg::TABLE_DEPTH), "insert into a full table")

endmodule
